>>> rtl/pia_pkg.sv
// Package for the PIA register port unit: payload types, command codes and register bits.
`default_nettype none

package pia_pkg;

	typedef enum logic [1:0] {
		CMD_READ    = 2'd0,
		CMD_WRITE   = 2'd1,
		CMD_CA1_EDGE = 2'd2,
		CMD_CB1_EDGE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		SEL_PORT_A = 2'd0,
		SEL_CTRL_A = 2'd1,
		SEL_PORT_B = 2'd2,
		SEL_CTRL_B = 2'd3
	} reg_sel_t;

	// Control register bit positions.
	localparam int unsigned CTRL_IRQ_EN   = 0;
	localparam int unsigned CTRL_EDGE_SEL = 1;
	localparam int unsigned CTRL_DATA_SEL = 2;
	localparam int unsigned CTRL_MUX_BIT  = 3;
	localparam int unsigned CTRL_FLAG1    = 7;

	// A control write keeps the low six bits; a data read clears the two flags.
	localparam logic [7:0] CTRL_KEEP_MASK = 8'h3F;

	typedef struct packed {
		cmd_t       cmd;
		reg_sel_t   reg_select;
		logic [7:0] write_data;
		logic       edge_rising;
		logic       edge_any;
		logic [7:0] port_a_pins;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_request;
		logic [7:0] port_a_out;
		logic [7:0] port_b_out;
		logic [1:0] mux_select;
	} out_item_t;

endpackage

`default_nettype wire

>>> rtl/pia_register_port_unit.sv
// Top level of the PIA register port unit: register file, edge flags and result register.
// An accepted transfer passes through the input register, then the result register, to the
// output; one transfer is accepted every cycle while the output drains.
// Throughput is one item per cycle unless the output stalls, set by the single state update
// in the result stage. Reset (arst_n low, asynchronous) clears all data, direction and control
// registers and empties both the input and result registers.
`default_nettype none

module pia_register_port_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire pia_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output pia_pkg::out_item_t      out_data
);

	logic               valid_s1;
	pia_pkg::in_item_t  item_s1;
	logic               advance;

	logic [7:0] port_a_data_q, port_b_data_q, dir_a_q, dir_b_q, ctrl_a_q, ctrl_b_q;
	logic [7:0] port_a_data_d, port_b_data_d, dir_a_d, dir_b_d, ctrl_a_d, ctrl_b_d;
	logic [7:0] read_data_d;
	logic       irq_d;
	logic       out_valid_q;
	pia_pkg::out_item_t out_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_comb begin
		port_a_data_d = port_a_data_q;
		port_b_data_d = port_b_data_q;
		dir_a_d       = dir_a_q;
		dir_b_d       = dir_b_q;
		ctrl_a_d      = ctrl_a_q;
		ctrl_b_d      = ctrl_b_q;
		read_data_d   = 8'd0;
		irq_d         = 1'b0;
		unique case (item_s1.cmd)
			pia_pkg::CMD_READ: begin
				unique case (item_s1.reg_select)
					pia_pkg::SEL_PORT_A: begin
						if (ctrl_a_q[pia_pkg::CTRL_DATA_SEL]) begin
							read_data_d = item_s1.port_a_pins;
							ctrl_a_d    = ctrl_a_q & pia_pkg::CTRL_KEEP_MASK;
						end else begin
							read_data_d = dir_a_q;
						end
					end
					pia_pkg::SEL_CTRL_A: read_data_d = ctrl_a_q;
					pia_pkg::SEL_PORT_B: begin
						if (ctrl_b_q[pia_pkg::CTRL_DATA_SEL]) begin
							read_data_d = port_b_data_q & dir_b_q;
							ctrl_b_d    = ctrl_b_q & pia_pkg::CTRL_KEEP_MASK;
						end else begin
							read_data_d = dir_b_q;
						end
					end
					pia_pkg::SEL_CTRL_B: read_data_d = ctrl_b_q;
					default: read_data_d = 8'd0;
				endcase
			end
			pia_pkg::CMD_WRITE: begin
				unique case (item_s1.reg_select)
					pia_pkg::SEL_PORT_A: begin
						if (ctrl_a_q[pia_pkg::CTRL_DATA_SEL]) port_a_data_d = item_s1.write_data;
						else dir_a_d = item_s1.write_data;
					end
					pia_pkg::SEL_CTRL_A: ctrl_a_d = item_s1.write_data & pia_pkg::CTRL_KEEP_MASK;
					pia_pkg::SEL_PORT_B: begin
						if (ctrl_b_q[pia_pkg::CTRL_DATA_SEL]) port_b_data_d = item_s1.write_data;
						else dir_b_d = item_s1.write_data;
					end
					pia_pkg::SEL_CTRL_B: ctrl_b_d = item_s1.write_data & pia_pkg::CTRL_KEEP_MASK;
					default: ;
				endcase
			end
			pia_pkg::CMD_CA1_EDGE: begin
				// CA1 may be told to flag on either edge.
				if (item_s1.edge_any ||
				    (item_s1.edge_rising == ctrl_a_q[pia_pkg::CTRL_EDGE_SEL])) begin
					ctrl_a_d[pia_pkg::CTRL_FLAG1] = 1'b1;
					irq_d = ctrl_a_q[pia_pkg::CTRL_IRQ_EN];
				end
			end
			pia_pkg::CMD_CB1_EDGE: begin
				if (item_s1.edge_rising == ctrl_b_q[pia_pkg::CTRL_EDGE_SEL]) begin
					ctrl_b_d[pia_pkg::CTRL_FLAG1] = 1'b1;
					irq_d = ctrl_b_q[pia_pkg::CTRL_IRQ_EN];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_a_data_q <= 8'd0;
			port_b_data_q <= 8'd0;
			dir_a_q       <= 8'd0;
			dir_b_q       <= 8'd0;
			ctrl_a_q      <= 8'd0;
			ctrl_b_q      <= 8'd0;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				port_a_data_q <= port_a_data_d;
				port_b_data_q <= port_b_data_d;
				dir_a_q       <= dir_a_d;
				dir_b_q       <= dir_b_d;
				ctrl_a_q      <= ctrl_a_d;
				ctrl_b_q      <= ctrl_b_d;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.read_data   <= read_data_d;
			out_q.irq_request <= irq_d;
			out_q.port_a_out  <= port_a_data_d;
			out_q.port_b_out  <= port_b_data_d;
			out_q.mux_select  <= {ctrl_b_d[pia_pkg::CTRL_MUX_BIT],
			                      ctrl_a_d[pia_pkg::CTRL_MUX_BIT]};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	// The input register only holds off new transfers when the result register is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a stalled result");

	// Reads and writes never raise an interrupt request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (item_s1.cmd == pia_pkg::CMD_READ || item_s1.cmd == pia_pkg::CMD_WRITE))
		|=> !out_q.irq_request)
		else $error("interrupt request on a bus access");

	// Only a read returns a nonzero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.cmd != pia_pkg::CMD_READ) |=> (out_q.read_data == 8'd0))
		else $error("read data on a non-read transfer");

	// A control A write leaves both flags clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.cmd == pia_pkg::CMD_WRITE &&
		 item_s1.reg_select == pia_pkg::SEL_CTRL_A) |=> (ctrl_a_q[7:6] == 2'b00))
		else $error("control A flags survived a control write");
`endif

endmodule

`default_nettype wire

>>> tb/pia_register_port_unit_tb.sv
// Self-checking testbench for the PIA register port unit: bursty sender, stalling receiver.
`timescale 1ns / 100ps

module pia_register_port_unit_tb;

	typedef struct {
		pia_pkg::in_item_t item;
		bit                drain_first;
	} bus_access_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	pia_pkg::in_item_t  in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	pia_pkg::out_item_t out_data;

	// Shadow copy of the adapter registers, advanced once per accepted transfer.
	logic [7:0] port_a_q;
	logic [7:0] port_b_q;
	logic [7:0] dir_a_q;
	logic [7:0] dir_b_q;
	logic [7:0] ctrl_a_q;
	logic [7:0] ctrl_b_q;

	bus_access_t        access_queue[$];
	pia_pkg::out_item_t predicted_results[$];

	int unsigned mismatch_count = 0;
	int unsigned result_count   = 0;
	int unsigned read_count     = 0;
	int unsigned write_count    = 0;
	int unsigned ca1_count      = 0;
	int unsigned cb1_count      = 0;
	int unsigned irq_count      = 0;
	int unsigned drain_count    = 0;

	bus_access_t        next_access;
	pia_pkg::out_item_t step_result;
	pia_pkg::out_item_t want;
	logic               drive_valid;
	pia_pkg::in_item_t  drive_data;
	int                 burst_left = 0;
	int                 gap_left   = 0;
	logic [15:0]        ready_pattern = 16'hFFFF;
	int                 ready_phase   = 0;
	int                 ri;

	pia_register_port_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic clear_registers();
		port_a_q = '0;
		port_b_q = '0;
		dir_a_q  = '0;
		dir_b_q  = '0;
		ctrl_a_q = '0;
		ctrl_b_q = '0;
	endtask

	// Applies one bus access or edge event to the shadow registers.
	task automatic apply_bus_access(input pia_pkg::in_item_t it,
			output pia_pkg::out_item_t res);
		logic hit;
		res = '0;
		hit = 1'b0;
		case (it.cmd)
			pia_pkg::CMD_READ: begin
				case (it.reg_select)
					pia_pkg::SEL_PORT_A: begin
						if (ctrl_a_q[pia_pkg::CTRL_DATA_SEL]) begin
							ctrl_a_q      = ctrl_a_q & pia_pkg::CTRL_KEEP_MASK;
							res.read_data = it.port_a_pins;
						end else begin
							res.read_data = dir_a_q;
						end
					end
					pia_pkg::SEL_CTRL_A: res.read_data = ctrl_a_q;
					pia_pkg::SEL_PORT_B: begin
						if (ctrl_b_q[pia_pkg::CTRL_DATA_SEL]) begin
							ctrl_b_q      = ctrl_b_q & pia_pkg::CTRL_KEEP_MASK;
							res.read_data = port_b_q & dir_b_q;
						end else begin
							res.read_data = dir_b_q;
						end
					end
					default: res.read_data = ctrl_b_q;
				endcase
			end
			pia_pkg::CMD_WRITE: begin
				case (it.reg_select)
					pia_pkg::SEL_PORT_A: begin
						if (ctrl_a_q[pia_pkg::CTRL_DATA_SEL]) port_a_q = it.write_data;
						else dir_a_q = it.write_data;
					end
					pia_pkg::SEL_CTRL_A: ctrl_a_q = it.write_data & pia_pkg::CTRL_KEEP_MASK;
					pia_pkg::SEL_PORT_B: begin
						if (ctrl_b_q[pia_pkg::CTRL_DATA_SEL]) port_b_q = it.write_data;
						else dir_b_q = it.write_data;
					end
					default: ctrl_b_q = it.write_data & pia_pkg::CTRL_KEEP_MASK;
				endcase
			end
			pia_pkg::CMD_CA1_EDGE: begin
				hit = it.edge_any || (it.edge_rising == ctrl_a_q[pia_pkg::CTRL_EDGE_SEL]);
				if (hit) begin
					ctrl_a_q[pia_pkg::CTRL_FLAG1] = 1'b1;
					res.irq_request               = ctrl_a_q[pia_pkg::CTRL_IRQ_EN];
				end
			end
			default: begin
				// The CB1 line has no any-edge mode.
				hit = (it.edge_rising == ctrl_b_q[pia_pkg::CTRL_EDGE_SEL]);
				if (hit) begin
					ctrl_b_q[pia_pkg::CTRL_FLAG1] = 1'b1;
					res.irq_request               = ctrl_b_q[pia_pkg::CTRL_IRQ_EN];
				end
			end
		endcase
		res.port_a_out = port_a_q;
		res.port_b_out = port_b_q;
		res.mux_select = {ctrl_b_q[pia_pkg::CTRL_MUX_BIT], ctrl_a_q[pia_pkg::CTRL_MUX_BIT]};
	endtask

	task automatic queue_access(input pia_pkg::cmd_t c, input pia_pkg::reg_sel_t s,
			input logic [7:0] wd, input logic rising, input logic any,
			input logic [7:0] pins, input bit drain);
		bus_access_t a;
		a.item.cmd         = c;
		a.item.reg_select  = s;
		a.item.write_data  = wd;
		a.item.edge_rising = rising;
		a.item.edge_any    = any;
		a.item.port_a_pins = pins;
		a.drain_first      = drain;
		access_queue.push_back(a);
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned exp_val);
		mismatch_count++;
		// Past the first few dozen, further lines add nothing but noise.
		if (mismatch_count <= 60)
			$display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
				result_count, what, got, exp_val);
	endtask

	// Driver: predicts each accepted transfer and presents queued transfers in bursts separated by random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				apply_bus_access(in_data, step_result);
				predicted_results.push_back(step_result);
				if (step_result.irq_request) irq_count++;
				case (in_data.cmd)
					pia_pkg::CMD_READ:     read_count++;
					pia_pkg::CMD_WRITE:    write_count++;
					pia_pkg::CMD_CA1_EDGE: ca1_count++;
					default:               cb1_count++;
				endcase
			end
			if (!in_valid || in_ready) begin
				drive_valid = 1'b0;
				drive_data  = in_data;
				if (gap_left > 0) begin
					gap_left--;
				end else if (access_queue.size() > 0 &&
						!(access_queue[0].drain_first && predicted_results.size() != 0)) begin
					next_access = access_queue.pop_front();
					drive_valid = 1'b1;
					drive_data  = next_access.item;
					if (next_access.drain_first) drain_count++;
					if (burst_left == 0) burst_left = $urandom_range(1, 40);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
				in_valid <= drive_valid;
				in_data  <= drive_data;
			end
		end
	end

	// Monitor: checks each result transfer and steps the receiver stall pattern.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				result_count++;
				if (predicted_results.size() == 0) begin
					report_mismatch("unexpected result", 32'(out_data), 32'd0);
				end else begin
					want = predicted_results.pop_front();
					if (out_data.read_data !== want.read_data)
						report_mismatch("read_data", 32'(out_data.read_data),
							32'(want.read_data));
					if (out_data.irq_request !== want.irq_request)
						report_mismatch("irq_request", 32'(out_data.irq_request),
							32'(want.irq_request));
					if (out_data.port_a_out !== want.port_a_out)
						report_mismatch("port_a_out", 32'(out_data.port_a_out),
							32'(want.port_a_out));
					if (out_data.port_b_out !== want.port_b_out)
						report_mismatch("port_b_out", 32'(out_data.port_b_out),
							32'(want.port_b_out));
					if (out_data.mux_select !== want.mux_select)
						report_mismatch("mux_select", 32'(out_data.mux_select),
							32'(want.mux_select));
				end
			end
			if (ready_phase == 15) begin
				ready_phase = 0;
				if ($urandom_range(0, 3) == 0) ready_pattern = 16'hFFFF;
				else ready_pattern = 16'($urandom()) | 16'h0001;
			end else begin
				ready_phase++;
			end
			out_ready <= ready_pattern[ready_phase];
		end
	end

	initial begin
		clear_registers();

		// Directed part: reset values, masking of control writes, data/direction
		// selection, the port B AND read, edge matching and flag clearing.
		queue_access(pia_pkg::CMD_READ,  pia_pkg::SEL_PORT_A, 8'h00, 1'b0, 1'b0, 8'hFF, 1'b0);
		queue_access(pia_pkg::CMD_READ,  pia_pkg::SEL_CTRL_A, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_READ,  pia_pkg::SEL_PORT_B, 8'h00, 1'b0, 1'b0, 8'hFF, 1'b0);
		queue_access(pia_pkg::CMD_READ,  pia_pkg::SEL_CTRL_B, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_WRITE, pia_pkg::SEL_PORT_A, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_WRITE, pia_pkg::SEL_PORT_B, 8'h0F, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_WRITE, pia_pkg::SEL_CTRL_A, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_WRITE, pia_pkg::SEL_CTRL_B, 8'hFC, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_WRITE, pia_pkg::SEL_PORT_A, 8'hA5, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_WRITE, pia_pkg::SEL_PORT_B, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_READ,  pia_pkg::SEL_PORT_B, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_CA1_EDGE, pia_pkg::SEL_PORT_A, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_CA1_EDGE, pia_pkg::SEL_PORT_A, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_READ,  pia_pkg::SEL_CTRL_A, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_READ,  pia_pkg::SEL_PORT_A, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_CA1_EDGE, pia_pkg::SEL_PORT_A, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_WRITE, pia_pkg::SEL_CTRL_A, 8'hC4, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_CA1_EDGE, pia_pkg::SEL_PORT_A, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_CB1_EDGE, pia_pkg::SEL_PORT_A, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_CB1_EDGE, pia_pkg::SEL_PORT_A, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_READ,  pia_pkg::SEL_CTRL_B, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_WRITE, pia_pkg::SEL_CTRL_B, 8'h03, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_CB1_EDGE, pia_pkg::SEL_PORT_A, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_CB1_EDGE, pia_pkg::SEL_PORT_A, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_READ,  pia_pkg::SEL_PORT_B, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_WRITE, pia_pkg::SEL_CTRL_B, 8'h07, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_access(pia_pkg::CMD_READ,  pia_pkg::SEL_PORT_B, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);

		// Random part; every few hundred transfers the sender drains the block first.
		for (ri = 0; ri < 1700; ri++)
			queue_access(pia_pkg::cmd_t'($urandom_range(0, 3)),
				pia_pkg::reg_sel_t'($urandom_range(0, 3)),
				8'($urandom()), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				8'($urandom()), (ri % 400) == 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (access_queue.size() != 0 || in_valid || predicted_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("checked %0d results: %0d reads, %0d writes, %0d CA1 and %0d CB1 events",
			result_count, read_count, write_count, ca1_count, cb1_count);
		$display("%0d interrupt requests predicted, %0d full drains by the sender",
			irq_count, drain_count);
		if (mismatch_count == 0) begin
			$display("[pia_register_port_unit] OK");
		end else begin
			$display("[pia_register_port_unit] ERROR");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timeout with %0d results still expected", predicted_results.size());
		$display("[pia_register_port_unit] ERROR");
		$finish;
	end

endmodule
